// ===== rtl/core/rsph_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rsph_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam int COORD_W = 16;
	localparam int SPEED_IN_W = 10;
	localparam int SPEED_W = 9;
	localparam int FIELD_CNT_W = 5;
	localparam logic [SPEED_W-1:0] SPEED_ONE = 9'd256;

	localparam logic [1:0] KIND_PUSH   = 2'd0;
	localparam logic [1:0] KIND_POP    = 2'd1;
	localparam logic [1:0] KIND_REMOVE = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	// cell operations
	localparam logic [1:0] CELL_HOLD = 2'd0;
	localparam logic [1:0] CELL_PUSH = 2'd1;
	localparam logic [1:0] CELL_POP  = 2'd2;
	localparam logic [1:0] CELL_ROT  = 2'd3;

	typedef struct packed {
		logic signed [COORD_W-1:0] left;
		logic signed [COORD_W-1:0] bottom;
		logic signed [COORD_W-1:0] right;
		logic signed [COORD_W-1:0] upper;
		logic [SPEED_W-1:0]        speed;
	} entry_t;

	typedef struct packed {
		logic [1:0]       op;
		logic             keep;
		logic [CNT_W-1:0] len;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/rsph_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsph_cell
	import rsph_pkg::*;
(
	input  wire logic             clk,
	input  wire cell_ctl_t        ctl,
	input  wire logic [IDX_W-1:0] idx,
	input  wire entry_t           up_entry,
	input  wire entry_t           dn_entry,
	input  wire entry_t           head_entry,
	output entry_t                entry
);

	entry_t           entry_q;
	logic [CNT_W-1:0] pos_next;

	assign pos_next = CNT_W'(idx) + CNT_W'(1);

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_PUSH: entry_q <= up_entry;
			CELL_POP:  entry_q <= dn_entry;
			CELL_ROT: begin
				// queue rotation: cells above the tail move toward the head,
				// the tail cell takes the old head word if it survives
				if (pos_next < ctl.len) begin
					entry_q <= dn_entry;
				end else if (pos_next == ctl.len && ctl.keep) begin
					entry_q <= head_entry;
				end
			end
			default: ;
		endcase
	end

	assign entry = entry_q;

endmodule

`default_nettype wire

// ===== rtl/core/rect_stack_point_hit_removal_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel | direction | handshake            | word
// input   | in        | in_valid / in_stall   | kind, corners, speed_in, point
// output  | out       | out_valid / out_stall | status, box, speed, counts
//
// Push, pop, unused kinds and a remove on an empty stack register their result
// on accept. A remove on a non-empty stack walks it through the head cell,
// one entry per cycle via a single box comparator; the last waits on out_stall.
// arst_n clears the fill count, the sequencer and the output valid; cells hold
// no reset. One word in flight: input stalls during a walk and while an
// unread result is stalled at the output.

module rect_stack_point_hit_removal_top
	import rsph_pkg::*;
(
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [1:0]                   kind,
	input  wire logic signed [COORD_W-1:0]    corner_a_x,
	input  wire logic signed [COORD_W-1:0]    corner_a_y,
	input  wire logic signed [COORD_W-1:0]    corner_b_x,
	input  wire logic signed [COORD_W-1:0]    corner_b_y,
	input  wire logic signed [SPEED_IN_W-1:0] speed_in,
	input  wire logic signed [COORD_W-1:0]    point_x,
	input  wire logic signed [COORD_W-1:0]    point_y,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [1:0]                        status,
	output logic signed [COORD_W-1:0]         left_out,
	output logic signed [COORD_W-1:0]         bottom_out,
	output logic signed [COORD_W-1:0]         right_out,
	output logic signed [COORD_W-1:0]         top_out,
	output logic [SPEED_W-1:0]                speed_out,
	output logic [FIELD_CNT_W-1:0]            removed_count,
	output logic [FIELD_CNT_W-1:0]            fill_level
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_WALK = 1'b1;

	logic                      state_q;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          len_q;
	logic [CNT_W-1:0]          steps_q;
	logic [CNT_W-1:0]          removed_q;
	logic signed [COORD_W-1:0] px_q;
	logic signed [COORD_W-1:0] py_q;

	logic                      out_valid_q;
	logic [1:0]                status_q;
	entry_t                    box_q;
	logic [CNT_W-1:0]          removed_out_q;
	logic [CNT_W-1:0]          fill_q;

	logic                      accept;
	logic                      out_free;
	logic                      walk_go;
	logic                      last;
	logic                      hit;
	logic                      is_full;
	logic                      is_empty;
	logic                      load_out;
	entry_t                    new_e;
	cell_ctl_t                 ctl;
	entry_t                    cell_e [DEPTH];

	logic [1:0]                st_d;
	entry_t                    box_d;
	logic [CNT_W-1:0]          removed_d;
	logic [CNT_W-1:0]          fill_d;

	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign is_empty = (count_q == '0);
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || !out_free;
	assign accept   = in_valid && !in_stall;
	assign walk_go  = (state_q == S_WALK) && ((steps_q != CNT_W'(1)) || out_free);
	assign last     = walk_go && (steps_q == CNT_W'(1));
	assign load_out = last || (accept && !(kind == KIND_REMOVE && !is_empty));

	// new word: order each axis, clamp speed to 0..1.0
	always_comb begin
		new_e.left   = (corner_a_x <= corner_b_x) ? corner_a_x : corner_b_x;
		new_e.right  = (corner_a_x <= corner_b_x) ? corner_b_x : corner_a_x;
		new_e.bottom = (corner_a_y <= corner_b_y) ? corner_a_y : corner_b_y;
		new_e.upper  = (corner_a_y <= corner_b_y) ? corner_b_y : corner_a_y;
		if (speed_in[SPEED_IN_W-1]) begin
			new_e.speed = '0;
		end else if (speed_in > $signed({1'b0, SPEED_ONE})) begin
			new_e.speed = SPEED_ONE;
		end else begin
			new_e.speed = speed_in[SPEED_W-1:0];
		end
	end

	// closed-box test on the head cell
	assign hit = (px_q >= cell_e[0].left) && (px_q <= cell_e[0].right) &&
	             (py_q >= cell_e[0].bottom) && (py_q <= cell_e[0].upper);

	always_comb begin
		ctl.op   = CELL_HOLD;
		ctl.keep = 1'b0;
		ctl.len  = len_q;
		if (walk_go) begin
			ctl.op   = CELL_ROT;
			ctl.keep = !hit;
		end else if (accept) begin
			if (kind == KIND_PUSH && !is_full) begin
				ctl.op = CELL_PUSH;
			end else if (kind == KIND_POP && !is_empty) begin
				ctl.op = CELL_POP;
			end
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t up_w;
		entry_t dn_w;
		if (i == 0) begin : g_head
			assign up_w = new_e;
		end else begin : g_mid
			assign up_w = cell_e[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign dn_w = cell_e[i];
		end else begin : g_body
			assign dn_w = cell_e[i+1];
		end
		rsph_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.idx        (IDX_W'(i)),
			.up_entry   (up_w),
			.dn_entry   (dn_w),
			.head_entry (cell_e[0]),
			.entry      (cell_e[i])
		);
	end

	always_comb begin
		st_d      = STAT_OK;
		box_d     = '0;
		removed_d = '0;
		fill_d    = count_q;
		if (last) begin
			removed_d = removed_q + CNT_W'(hit);
			fill_d    = len_q - CNT_W'(hit);
		end else begin
			case (kind)
				KIND_PUSH: begin
					if (is_full) begin
						st_d = STAT_FULL;
					end else begin
						fill_d = count_q + CNT_W'(1);
					end
				end
				KIND_POP: begin
					if (is_empty) begin
						st_d = STAT_EMPTY;
					end else begin
						box_d  = cell_e[0];
						fill_d = count_q - CNT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			len_q       <= '0;
			steps_q     <= '0;
			removed_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				case (kind)
					KIND_PUSH: begin
						if (!is_full) count_q <= count_q + CNT_W'(1);
					end
					KIND_POP: begin
						if (!is_empty) count_q <= count_q - CNT_W'(1);
					end
					KIND_REMOVE: begin
						if (!is_empty) begin
							state_q   <= S_WALK;
							len_q     <= count_q;
							steps_q   <= count_q;
							removed_q <= '0;
						end
					end
					default: ;
				endcase
			end
			if (walk_go) begin
				len_q     <= len_q - CNT_W'(hit);
				removed_q <= removed_q + CNT_W'(hit);
				steps_q   <= steps_q - CNT_W'(1);
				if (last) begin
					state_q <= S_IDLE;
					count_q <= len_q - CNT_W'(hit);
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= point_x;
			py_q <= point_y;
		end
		if (load_out) begin
			status_q      <= st_d;
			box_q         <= box_d;
			removed_out_q <= removed_d;
			fill_q        <= fill_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign left_out      = box_q.left;
	assign bottom_out    = box_q.bottom;
	assign right_out     = box_q.right;
	assign top_out       = box_q.upper;
	assign speed_out     = box_q.speed;
	assign removed_count = FIELD_CNT_W'(removed_out_q);
	assign fill_level    = FIELD_CNT_W'(fill_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fill count beyond depth");

	a_walk_conserve: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |->
		({1'b0, len_q} + {1'b0, removed_q} == {1'b0, count_q}))
		else $error("walk lost track of entries");

	a_walk_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> in_stall)
		else $error("input taken during walk");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == KIND_POP && is_empty) |=>
		(out_valid && status == STAT_EMPTY && fill_level == '0))
		else $error("empty pop not reported");

	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == KIND_PUSH && is_full) |=>
		($stable(count_q) && status == STAT_FULL))
		else $error("full push changed state");

endmodule

`default_nettype wire

// ===== test/rect_stack_check.sv =====
`timescale 1ns / 1ps

module rect_stack_check
	import rsph_pkg::*;
(
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic                         in_stall,
	input  wire logic [1:0]                   kind,
	input  wire logic signed [COORD_W-1:0]    corner_a_x,
	input  wire logic signed [COORD_W-1:0]    corner_a_y,
	input  wire logic signed [COORD_W-1:0]    corner_b_x,
	input  wire logic signed [COORD_W-1:0]    corner_b_y,
	input  wire logic signed [SPEED_IN_W-1:0] speed_in,
	input  wire logic signed [COORD_W-1:0]    point_x,
	input  wire logic signed [COORD_W-1:0]    point_y,
	input  wire logic                         out_valid,
	input  wire logic                         out_stall,
	input  wire logic [1:0]                   status,
	input  wire logic signed [COORD_W-1:0]    left_out,
	input  wire logic signed [COORD_W-1:0]    bottom_out,
	input  wire logic signed [COORD_W-1:0]    right_out,
	input  wire logic signed [COORD_W-1:0]    top_out,
	input  wire logic [SPEED_W-1:0]           speed_out,
	input  wire logic [FIELD_CNT_W-1:0]       removed_count,
	input  wire logic [FIELD_CNT_W-1:0]       fill_level,
	output int                                errors,
	output int                                pending,
	output int                                full_drops,
	output int                                empty_pops,
	output int                                hit_removals
);

	typedef struct {
		logic signed [COORD_W-1:0] left;
		logic signed [COORD_W-1:0] bottom;
		logic signed [COORD_W-1:0] right;
		logic signed [COORD_W-1:0] upper;
		logic [SPEED_W-1:0]        speed;
	} box_t;

	typedef struct {
		logic [1:0]                status;
		logic signed [COORD_W-1:0] left;
		logic signed [COORD_W-1:0] bottom;
		logic signed [COORD_W-1:0] right;
		logic signed [COORD_W-1:0] upper;
		logic [SPEED_W-1:0]        speed;
		logic [FIELD_CNT_W-1:0]    removed;
		logic [FIELD_CNT_W-1:0]    fill;
	} stack_reply_t;

	box_t         box_stack [DEPTH];
	int           box_count;
	stack_reply_t replies_due [$];
	stack_reply_t next_reply;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
	endtask

	// updates the stack copy for one accepted word and builds its reply
	task automatic apply_stack_word(output stack_reply_t r);
		box_t e;
		int   spd;
		int   kept;
		r = '{default: '0};
		r.status = STAT_OK;
		case (kind)
			KIND_PUSH: begin
				if (box_count >= DEPTH) begin
					r.status = STAT_FULL;
					full_drops++;
				end else begin
					spd = int'(speed_in);
					if (spd < 0)
						spd = 0;
					else if (spd > int'(SPEED_ONE))
						spd = int'(SPEED_ONE);
					e.left   = (corner_a_x <= corner_b_x) ? corner_a_x : corner_b_x;
					e.right  = (corner_a_x <= corner_b_x) ? corner_b_x : corner_a_x;
					e.bottom = (corner_a_y <= corner_b_y) ? corner_a_y : corner_b_y;
					e.upper  = (corner_a_y <= corner_b_y) ? corner_b_y : corner_a_y;
					e.speed  = SPEED_W'(spd);
					box_stack[box_count] = e;
					box_count++;
				end
			end
			KIND_POP: begin
				if (box_count == 0) begin
					r.status = STAT_EMPTY;
					empty_pops++;
				end else begin
					box_count--;
					e = box_stack[box_count];
					r.left   = e.left;
					r.bottom = e.bottom;
					r.right  = e.right;
					r.upper  = e.upper;
					r.speed  = e.speed;
				end
			end
			KIND_REMOVE: begin
				kept = 0;
				for (int i = 0; i < box_count; i++) begin
					e = box_stack[i];
					// closed box: edges count as hits
					if (point_x >= e.left && point_x <= e.right &&
							point_y >= e.bottom && point_y <= e.upper) begin
						r.removed++;
					end else begin
						box_stack[kept] = e;
						kept++;
					end
				end
				hit_removals += int'(r.removed);
				box_count = kept;
			end
			default: ;
		endcase
		r.fill = FIELD_CNT_W'(box_count);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_count = 0;
			replies_due.delete();
		end else begin
			if (in_valid && !in_stall) begin
				apply_stack_word(next_reply);
				replies_due.push_back(next_reply);
			end
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					report_mismatch("result word with none due");
				end else begin
					next_reply = replies_due.pop_front();
					check_field("status", 16'(status), 16'(next_reply.status));
					check_field("left_out", left_out, next_reply.left);
					check_field("bottom_out", bottom_out, next_reply.bottom);
					check_field("right_out", right_out, next_reply.right);
					check_field("top_out", top_out, next_reply.upper);
					check_field("speed_out", 16'(speed_out), 16'(next_reply.speed));
					check_field("removed_count", 16'(removed_count),
						16'(next_reply.removed));
					check_field("fill_level", 16'(fill_level), 16'(next_reply.fill));
				end
			end
		end
		pending = replies_due.size();
	end

endmodule

// ===== test/rect_stack_point_hit_removal_top_test.sv =====
`timescale 1ns / 1ps

module rect_stack_point_hit_removal_top_test;
	import rsph_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_WORDS = 600;

	typedef struct {
		logic [1:0]                   kind;
		logic signed [COORD_W-1:0]    ax;
		logic signed [COORD_W-1:0]    ay;
		logic signed [COORD_W-1:0]    bx;
		logic signed [COORD_W-1:0]    by;
		logic signed [SPEED_IN_W-1:0] spd;
		logic signed [COORD_W-1:0]    px;
		logic signed [COORD_W-1:0]    py;
	} rect_cmd_t;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic [1:0]                   kind;
	logic signed [COORD_W-1:0]    corner_a_x;
	logic signed [COORD_W-1:0]    corner_a_y;
	logic signed [COORD_W-1:0]    corner_b_x;
	logic signed [COORD_W-1:0]    corner_b_y;
	logic signed [SPEED_IN_W-1:0] speed_in;
	logic signed [COORD_W-1:0]    point_x;
	logic signed [COORD_W-1:0]    point_y;
	logic                         out_valid;
	logic                         out_stall;
	logic [1:0]                   status;
	logic signed [COORD_W-1:0]    left_out;
	logic signed [COORD_W-1:0]    bottom_out;
	logic signed [COORD_W-1:0]    right_out;
	logic signed [COORD_W-1:0]    top_out;
	logic [SPEED_W-1:0]           speed_out;
	logic [FIELD_CNT_W-1:0]       removed_count;
	logic [FIELD_CNT_W-1:0]       fill_level;

	int errors;
	int pending;
	int full_drops;
	int empty_pops;
	int hit_removals;

	int send_idle_pct;
	int recv_idle_pct;
	int words_sent;
	rect_cmd_t recent_boxes [$];

	rect_stack_point_hit_removal_top uut (.*);
	rect_stack_check stack_check (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// mostly near the origin so boxes overlap, sometimes anywhere
	function automatic logic signed [COORD_W-1:0] rand_coord();
		if ($urandom_range(0, 9) < 7)
			return COORD_W'(int'($urandom_range(0, 400)) - 200);
		return COORD_W'($urandom);
	endfunction

	function automatic rect_cmd_t rand_cmd();
		rect_cmd_t c;
		c.kind = 2'($urandom);
		c.ax   = rand_coord();
		c.ay   = rand_coord();
		c.bx   = rand_coord();
		c.by   = rand_coord();
		c.spd  = SPEED_IN_W'($urandom);
		c.px   = rand_coord();
		c.py   = rand_coord();
		return c;
	endfunction

	function automatic rect_cmd_t make_push(input int ax, input int ay, input int bx,
			input int by, input int spd);
		rect_cmd_t c;
		c      = rand_cmd();
		c.kind = KIND_PUSH;
		c.ax   = COORD_W'(ax);
		c.ay   = COORD_W'(ay);
		c.bx   = COORD_W'(bx);
		c.by   = COORD_W'(by);
		c.spd  = SPEED_IN_W'(spd);
		return c;
	endfunction

	function automatic rect_cmd_t make_probe(input logic [1:0] k, input int px, input int py);
		rect_cmd_t c;
		c      = rand_cmd();
		c.kind = k;
		c.px   = COORD_W'(px);
		c.py   = COORD_W'(py);
		return c;
	endfunction

	task automatic send_word(input rect_cmd_t c);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= c.kind;
		corner_a_x <= c.ax;
		corner_a_y <= c.ay;
		corner_b_x <= c.bx;
		corner_b_y <= c.by;
		speed_in   <= c.spd;
		point_x    <= c.px;
		point_y    <= c.py;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
	endtask

	initial begin
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		rect_cmd_t c;
		rect_cmd_t b;
		int        mode;
		int        r;
		int        lo_x;
		int        hi_x;
		int        lo_y;
		int        hi_y;
		int        push_cut [3];
		int        pop_cut [3];
		// modes: fill up, drain, mixed
		push_cut = '{65, 20, 40};
		pop_cut  = '{75, 70, 65};
		mode     = 0;

		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		kind       <= KIND_PUSH;
		corner_a_x <= '0;
		corner_a_y <= '0;
		corner_b_x <= '0;
		corner_b_y <= '0;
		speed_in   <= '0;
		point_x    <= '0;
		point_y    <= '0;
		words_sent = 0;
		send_idle_pct = 36;
		recv_idle_pct = 67;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty stack, unused kind, then fill past the top
		send_word(make_probe(KIND_POP, 0, 0));
		send_word(make_probe(KIND_REMOVE, 0, 0));
		send_word(make_probe(KIND_UNUSED, 0, 0));
		send_word(make_push(-32768, -32768, 32767, 32767, -512));
		send_word(make_push(32767, 32767, -32768, -32768, 511));
		send_word(make_push(10, 20, -5, -7, 256));
		send_word(make_push(3, 3, 3, 3, 257));
		send_word(make_push(-100, 40, 60, -90, -1));
		for (int i = 0; i < 12; i++)
			send_word(make_push(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
				(i == 0) ? 0 : int'($urandom_range(0, 1023))));
		send_word(make_probe(KIND_POP, 0, 0));
		// corner of the third box, then the degenerate box, then a far corner
		send_word(make_probe(KIND_REMOVE, -5, 20));
		send_word(make_probe(KIND_REMOVE, 3, 3));
		send_word(make_probe(KIND_REMOVE, 32767, -32768));
		send_word(make_probe(KIND_POP, 0, 0));

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 67 : 0;
			recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 36 : 0;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (n % 32 == 0)
					mode = $urandom_range(0, 2);
				r = $urandom_range(0, 99);
				c = rand_cmd();
				if (r < push_cut[mode]) begin
					c.kind = KIND_PUSH;
					recent_boxes.push_back(c);
					if (recent_boxes.size() > DEPTH)
						void'(recent_boxes.pop_front());
				end else if (r < pop_cut[mode]) begin
					c.kind = KIND_POP;
				end else if (r < 95) begin
					c.kind = KIND_REMOVE;
					// aim most probes at a box pushed lately, some on its edge
					if (recent_boxes.size() != 0 && $urandom_range(0, 9) < 7) begin
						b = recent_boxes[$urandom_range(0, recent_boxes.size() - 1)];
						lo_x = (b.ax < b.bx) ? b.ax : b.bx;
						hi_x = (b.ax < b.bx) ? b.bx : b.ax;
						lo_y = (b.ay < b.by) ? b.ay : b.by;
						hi_y = (b.ay < b.by) ? b.by : b.ay;
						c.px = COORD_W'(lo_x + int'($urandom_range(0, hi_x - lo_x)));
						c.py = COORD_W'(lo_y + int'($urandom_range(0, hi_y - lo_y)));
						if ($urandom_range(0, 3) == 0)
							c.px = COORD_W'($urandom_range(0, 1) ? hi_x : lo_x);
						if ($urandom_range(0, 3) == 0)
							c.py = COORD_W'($urandom_range(0, 1) ? hi_y : lo_y);
					end
				end else begin
					c.kind = KIND_UNUSED;
				end
				send_word(c);
			end
		end
		in_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);

		$display("ran %0d words through three sender/receiver idle mixes", words_sent);
		$display("%0d pushes dropped when full, %0d pops on empty, %0d boxes hit by points",
			full_drops, empty_pops, hit_removals);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== rect_stack_point_hit_removal_top.f =====
rtl/core/rsph_pkg.sv
rtl/core/rsph_cell.sv
rtl/core/rect_stack_point_hit_removal_top.sv
test/rect_stack_check.sv
test/rect_stack_point_hit_removal_top_test.sv
